### hw/rtl/tpml_pkg.sv
// ----------------------------------------------------------------------------
// tpml_pkg: shared types and constants for the tree path-minimum unit.
// Holds the payload widths, the no-edge weight, the root vertex, the action codes and a minimum helper.
// ----------------------------------------------------------------------------
package tpml_pkg;

   localparam int VERTEX_W = 16;
   localparam int WEIGHT_W = 24;
   localparam int DEPTH_W  = 16;

   localparam logic [WEIGHT_W-1:0] NO_EDGE = 24'd10000000;
   localparam logic [VERTEX_W-1:0] ROOT    = 16'd1;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef logic [VERTEX_W-1:0] vertex_type;
   typedef logic [WEIGHT_W-1:0] weight_type;
   typedef logic [DEPTH_W-1:0]  depth_type;

   function automatic weight_type wmin(weight_type a, weight_type b);
      return (a < b) ? a : b;
   endfunction

endpackage

### hw/rtl/tree_path_min_binary_lifting_unit.sv
// ----------------------------------------------------------------------------
// tree_path_min_binary_lifting_unit: path-minimum queries by binary lifting.
// A load writes the depth and the level-zero table entry, then for every higher
// level does two dependent table reads and a write.
// A query does two depth reads, up to JUMP_LEVELS lift steps and JUMP_LEVELS
// paired steps, each step a read phase and a use phase, and then a final pair.
// One request at a time; reset clears control state only, tables are undefined.
// ----------------------------------------------------------------------------
module tree_path_min_binary_lifting_unit #(
   parameter int MAX_NODES   = 65536,
   parameter int JUMP_LEVELS = 17
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_action,
   input  tpml_pkg::vertex_type req_vertex,
   input  tpml_pkg::vertex_type req_parent,
   input  tpml_pkg::weight_type req_weight,
   input  tpml_pkg::vertex_type req_query_x,
   input  tpml_pkg::vertex_type req_query_y,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output tpml_pkg::weight_type rsp_path_minimum
);
   import tpml_pkg::*;

   localparam int NW = $clog2(MAX_NODES);
   localparam int SW = $clog2(MAX_NODES * JUMP_LEVELS);
   localparam int KW = $clog2(JUMP_LEVELS + 1);
   localparam logic [KW-1:0] KLAST = KW'(JUMP_LEVELS - 1);

   typedef enum logic [11:0] {
      S_IDLE  = 12'b000000000001,
      S_LDEP  = 12'b000000000010,
      S_LWR0  = 12'b000000000100,
      S_LRD1  = 12'b000000001000,
      S_LRD2  = 12'b000000010000,
      S_LWRK  = 12'b000000100000,
      S_QDEP  = 12'b000001000000,
      S_QCMP  = 12'b000010000000,
      S_QLIFT = 12'b000100000000,
      S_QPAIR = 12'b001000000000,
      S_QEND  = 12'b010000000000,
      S_QFIN  = 12'b100000000000
   } state_type;

   state_type  state_ff, state_in;
   logic [KW-1:0] k_ff, k_in;
   vertex_type v_ff, v_in, b_ff, b_in;
   vertex_type mid_ff, mid_in;
   weight_type lo_ff, lo_in, best_ff, best_in;
   depth_type  dx_ff, dx_in, delta_ff, delta_in;
   logic       rv_ff, rv_in;
   weight_type rd_ff, rd_in;

   logic       jwr_en, dwr_en;
   logic [SW-1:0] jwr_addr, ra, rb;
   vertex_type jwr_anc, anc_a, anc_b;
   weight_type jwr_min, min_a, min_b;
   logic [NW-1:0] dwr_addr, drd_addr;
   depth_type  dwr_data, drd_data;

   function automatic logic [SW-1:0] slot(vertex_type v, logic [KW-1:0] k);
      logic [NW-1:0] n;
      n = NW'(v);
      return SW'(n) * SW'(JUMP_LEVELS) + SW'(k);
   endfunction

   function automatic vertex_type vx(vertex_type v);
      return vertex_type'(NW'(v));
   endfunction

   tpml_tables #(.MAX_NODES(MAX_NODES), .JUMP_LEVELS(JUMP_LEVELS)) u_tables (
      .clock, .jwr_en, .jwr_addr, .jwr_anc, .jwr_min,
      .jrd_addr_a(ra), .jrd_addr_b(rb),
      .jrd_anc_a(anc_a), .jrd_min_a(min_a), .jrd_anc_b(anc_b), .jrd_min_b(min_b),
      .dwr_en, .dwr_addr, .dwr_data, .drd_addr, .drd_data
   );

   wire accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE) || (rv_ff && rsp_stall);
   assign rsp_valid = rv_ff;
   assign rsp_path_minimum = rd_ff;

   always_comb begin
      state_in = state_ff; k_in = k_ff; v_in = v_ff; b_in = b_ff;
      mid_in = mid_ff; lo_in = lo_ff; best_in = best_ff; dx_in = dx_ff;
      delta_in = delta_ff; rv_in = rv_ff && rsp_stall; rd_in = rd_ff;
      jwr_en = 1'b0; jwr_addr = slot(v_ff, k_ff); jwr_anc = mid_ff; jwr_min = lo_ff;
      dwr_en = 1'b0; dwr_addr = NW'(v_ff); dwr_data = drd_data + 16'd1;
      drd_addr = NW'(b_ff);
      ra = slot(v_ff, k_ff); rb = slot(b_ff, k_ff);
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               k_in = '0;
               if (req_action == ACT_LOAD) begin
                  v_in = vx(req_vertex);
                  if (vx(req_vertex) == ROOT) begin
                     mid_in = ROOT; lo_in = NO_EDGE;
                  end else begin
                     mid_in = vx(req_parent);
                     lo_in = (req_weight > NO_EDGE) ? NO_EDGE : req_weight;
                  end
                  b_in = vx(req_parent);
                  drd_addr = NW'(vx(req_parent));
                  state_in = S_LDEP;
               end else begin
                  v_in = vx(req_query_x); b_in = vx(req_query_y);
                  best_in = NO_EDGE;
                  mid_in = '0;
                  state_in = S_QDEP;
               end
            end
         end
         S_LDEP: begin
            // Depth of parent is on drd_data now.
            dwr_en = 1'b1;
            if (v_ff == ROOT) dwr_data = '0;
            state_in = S_LWR0;
         end
         S_LWR0: begin
            jwr_en = 1'b1;
            k_in = KW'(1);
            state_in = (JUMP_LEVELS > 1) ? S_LRD1 : S_IDLE;
         end
         S_LRD1: begin
            ra = slot(v_ff, k_ff - KW'(1));
            state_in = S_LRD2;
         end
         S_LRD2: begin
            mid_in = vx(anc_a); lo_in = min_a;
            ra = slot(vx(anc_a), k_ff - KW'(1));
            state_in = S_LWRK;
         end
         S_LWRK: begin
            jwr_en = 1'b1; jwr_anc = vx(anc_a); jwr_min = wmin(lo_ff, min_a);
            k_in = k_ff + KW'(1);
            state_in = (k_ff == KLAST) ? S_IDLE : S_LRD1;
         end
         S_QDEP: begin
            drd_addr = NW'(v_ff);
            state_in = S_QCMP;
         end
         S_QCMP: begin
            // drd_data holds depth of x; read y next.
            dx_in = drd_data;
            drd_addr = NW'(b_ff);
            state_in = S_QEND;
            k_in = '0;
         end
         S_QEND: begin
            if (dx_ff > drd_data) begin
               delta_in = dx_ff - drd_data;
            end else begin
               v_in = b_ff; b_in = v_ff; delta_in = drd_data - dx_ff;
            end
            state_in = S_QLIFT;
         end
         S_QLIFT: begin
            // Two-phase: odd pass issues read, even pass consumes it.
            ra = slot(v_ff, k_ff);
            if (mid_ff[0]) begin
               mid_in = '0;
               if (delta_ff[0]) begin
                  best_in = wmin(best_ff, min_a); v_in = vx(anc_a);
               end
               delta_in = delta_ff >> 1;
               k_in = k_ff + KW'(1);
            end else if (delta_ff == '0 || k_ff == KW'(JUMP_LEVELS)) begin
               k_in = KLAST; mid_in = '0; state_in = S_QPAIR;
            end else begin
               mid_in = vertex_type'(1);
            end
         end
         S_QPAIR: begin
            if (mid_ff[0]) begin
               mid_in = '0;
               if (vx(anc_a) != vx(anc_b)) begin
                  best_in = wmin(best_ff, wmin(min_a, min_b));
                  v_in = vx(anc_a); b_in = vx(anc_b);
               end
               if (k_ff == '0) begin
                  state_in = S_QFIN;
               end else begin
                  k_in = k_ff - KW'(1);
               end
            end else begin
               mid_in = vertex_type'(1);
            end
         end
         S_QFIN: begin
            if (mid_ff[0]) begin
               if (v_ff != b_ff) rd_in = wmin(best_ff, wmin(min_a, min_b));
               else rd_in = best_ff;
               rv_in = 1'b1; mid_in = '0;
               state_in = S_IDLE;
            end else begin
               k_in = '0; mid_in = vertex_type'(1);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; rv_ff <= 1'b0; mid_ff <= '0;
      end else begin
         state_ff <= state_in; rv_ff <= rv_in; mid_ff <= mid_in;
      end
      k_ff <= k_in; v_ff <= v_in; b_ff <= b_in; lo_ff <= lo_in;
      best_ff <= best_in; dx_ff <= dx_in; delta_ff <= delta_in; rd_ff <= rd_in;
   end

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> req_stall) else $error("request taken while busy");
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rsp_stall |=> rv_ff && $stable(rd_ff)) else $error("result lost");
   a_bound: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> rd_ff <= NO_EDGE) else $error("result out of range");

endmodule

### hw/rtl/tpml_tables.sv
// ----------------------------------------------------------------------------
// tpml_tables: jump tables and depth store.
// One write port and two registered read ports on the jump table; one read and
// one write port on the depth store. Read data is registered and appears in the
// cycle after the address.
// ----------------------------------------------------------------------------
module tpml_tables #(
   parameter int MAX_NODES   = 65536,
   parameter int JUMP_LEVELS = 17
) (
   input  logic                                        clock,
   input  logic                                        jwr_en,
   input  logic [$clog2(MAX_NODES*JUMP_LEVELS)-1:0]    jwr_addr,
   input  tpml_pkg::vertex_type                        jwr_anc,
   input  tpml_pkg::weight_type                        jwr_min,
   input  logic [$clog2(MAX_NODES*JUMP_LEVELS)-1:0]    jrd_addr_a,
   input  logic [$clog2(MAX_NODES*JUMP_LEVELS)-1:0]    jrd_addr_b,
   output tpml_pkg::vertex_type                        jrd_anc_a,
   output tpml_pkg::weight_type                        jrd_min_a,
   output tpml_pkg::vertex_type                        jrd_anc_b,
   output tpml_pkg::weight_type                        jrd_min_b,
   input  logic                                        dwr_en,
   input  logic [$clog2(MAX_NODES)-1:0]                dwr_addr,
   input  tpml_pkg::depth_type                         dwr_data,
   input  logic [$clog2(MAX_NODES)-1:0]                drd_addr,
   output tpml_pkg::depth_type                         drd_data
);
   import tpml_pkg::*;

   localparam int SLOTS = MAX_NODES * JUMP_LEVELS;

   vertex_type anc_mem [SLOTS];
   weight_type min_mem [SLOTS];
   depth_type  dep_mem [MAX_NODES];

   always_ff @(posedge clock) begin
      if (jwr_en) begin
         anc_mem[jwr_addr] <= jwr_anc;
         min_mem[jwr_addr] <= jwr_min;
      end
      jrd_anc_a <= anc_mem[jrd_addr_a];
      jrd_min_a <= min_mem[jrd_addr_a];
      jrd_anc_b <= anc_mem[jrd_addr_b];
      jrd_min_b <= min_mem[jrd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (dwr_en) begin
         dep_mem[dwr_addr] <= dwr_data;
      end
      drd_data <= dep_mem[drd_addr];
   end

endmodule
